// File: hw/rtl/lidar_point_ring_and_time_tagger_macros.svh
// Assertion helpers used by the checker module.
`ifndef LIDAR_POINT_RING_AND_TIME_TAGGER_MACROS_SVH
`define LIDAR_POINT_RING_AND_TIME_TAGGER_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define LPRT_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lprt assertion failed");

// Next-cycle implication, sampled on clk, off while rst is high.
`define LPRT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lprt assertion failed");

`endif

// File: hw/rtl/lprt_pkg.sv
package lprt_pkg;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int MAX_LINES_DEF    = 64;

  localparam int COORD_W  = 24;
  localparam int INTEN_W  = 16;
  localparam int REFL_W   = 8;
  localparam int RING_W   = 6;
  localparam int PERIOD_W = 30;
  localparam int SL_W     = 7;
  localparam int ANG_W    = 16;

  // CORDIC datapath: 8 guard bits on coordinates, 2^32 accumulator units per turn
  localparam int GUARD    = 8;
  localparam int CW       = 36;
  localparam int AW       = 35;
  localparam int ANG_LSB  = 16;
  localparam logic signed [AW-1:0] ANG_QUARTER = AW'(1073741824);
  localparam logic signed [AW-1:0] ANG_ROUND   = AW'(32768);

  // Radius square root
  localparam int SQ_W      = 2*COORD_W - 1;
  localparam int RAD_SHIFT = 16;
  localparam int RAD_W     = 64;
  localparam int ROOT_W    = 32;

  // Configuration port
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;
  localparam logic [1:0] REG_SCAN_LINES   = 2'd0;
  localparam logic [1:0] REG_ELEV_MIN     = 2'd1;
  localparam logic [1:0] REG_ELEV_MAX     = 2'd2;
  localparam logic [1:0] REG_FRAME_PERIOD = 2'd3;

  localparam logic [SL_W-1:0]            RST_SCAN_LINES   = SL_W'(16);
  localparam logic signed [ANG_W-1:0]    RST_ELEV_MIN     = -ANG_W'(1274);
  localparam logic signed [ANG_W-1:0]    RST_ELEV_MAX     = ANG_W'(9466);
  localparam logic [PERIOD_W-1:0]        RST_FRAME_PERIOD = PERIOD_W'(100000000);

  typedef struct packed {
    logic signed [COORD_W-1:0] x_out;
    logic signed [COORD_W-1:0] y_out;
    logic signed [COORD_W-1:0] z_out;
    logic [REFL_W-1:0]         reflectivity;
    logic [RING_W-1:0]         ring_line;
    logic [PERIOD_W-1:0]       time_ofs;
    logic                      last_out;
  } res_t;

  // atan(2^-i) in units of 2^31/pi, rounded to nearest
  function automatic logic signed [AW-1:0] atan_val(input int idx);
    logic signed [AW-1:0] r;
    case (idx)
      0:  r = AW'(536870912);
      1:  r = AW'(316933406);
      2:  r = AW'(167458907);
      3:  r = AW'(85004756);
      4:  r = AW'(42667331);
      5:  r = AW'(21354465);
      6:  r = AW'(10679838);
      7:  r = AW'(5340245);
      8:  r = AW'(2670163);
      9:  r = AW'(1335087);
      10: r = AW'(667544);
      11: r = AW'(333772);
      12: r = AW'(166886);
      13: r = AW'(83443);
      14: r = AW'(41722);
      15: r = AW'(20861);
      16: r = AW'(10430);
      17: r = AW'(5215);
      18: r = AW'(2608);
      19: r = AW'(1304);
      20: r = AW'(652);
      21: r = AW'(326);
      22: r = AW'(163);
      23: r = AW'(81);
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// File: hw/rtl/lprt_point_if.sv
interface lprt_point_if import lprt_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] x;
  logic signed [COORD_W-1:0] y;
  logic signed [COORD_W-1:0] z;
  logic signed [INTEN_W-1:0] intensity;
  logic                      last_point;

  modport source(output valid, x, y, z, intensity, last_point, input ready);
  modport sink(input valid, x, y, z, intensity, last_point, output ready);
endinterface

// File: hw/rtl/lprt_result_if.sv
interface lprt_result_if import lprt_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] x_out;
  logic signed [COORD_W-1:0] y_out;
  logic signed [COORD_W-1:0] z_out;
  logic [REFL_W-1:0]         reflectivity;
  logic [RING_W-1:0]         ring_line;
  logic [PERIOD_W-1:0]       time_ofs;
  logic                      last_out;

  modport source(output valid, x_out, y_out, z_out, reflectivity, ring_line, time_ofs,
                 last_out, input ready);
  modport sink(input valid, x_out, y_out, z_out, reflectivity, ring_line, time_ofs,
               last_out, output ready);
endinterface

// File: hw/rtl/lprt_isqrt.sv
module lprt_isqrt import lprt_pkg::*; #(
  parameter int TW = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              v_in,
  input  logic [RAD_W-1:0]  rad_in,
  input  logic [TW-1:0]     tag_in,
  output logic              v_out,
  output logic [ROOT_W-1:0] root_out,
  output logic [TW-1:0]     tag_out
);

  localparam int REM_W = ROOT_W + 3;

  logic [RAD_W-1:0]  rad [0:ROOT_W-1];
  logic [REM_W-1:0]  rem [0:ROOT_W-1];
  logic [ROOT_W-1:0] q   [0:ROOT_W];
  logic [TW-1:0]     tg  [0:ROOT_W];
  logic              v   [0:ROOT_W];

  assign rad[0] = rad_in;
  assign rem[0] = '0;
  assign q[0]   = '0;
  assign tg[0]  = tag_in;
  assign v[0]   = v_in;

  // One root bit per stage, two radicand bits brought down each time
  for (genvar k = 0; k < ROOT_W; k++) begin : g_st
    logic [REM_W-1:0] rc;
    logic [REM_W-1:0] trial;
    logic             take;

    assign rc    = {rem[k][REM_W-3:0], rad[k][RAD_W-1 -: 2]};
    assign trial = {1'b0, q[k], 2'b01};
    assign take  = rc >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k+1] <= 1'b0;
      end else if (en) begin
        v[k+1] <= v[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        q[k+1]  <= {q[k][ROOT_W-2:0], take};
        tg[k+1] <= tg[k];
      end
    end

    if (k < ROOT_W - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          rem[k+1] <= take ? rc - trial : rc;
          rad[k+1] <= {rad[k][RAD_W-3:0], 2'b00};
        end
      end
    end
  end

  assign v_out    = v[ROOT_W];
  assign root_out = q[ROOT_W];
  assign tag_out  = tg[ROOT_W];

endmodule

// File: hw/rtl/lprt_cordic.sv
module lprt_cordic import lprt_pkg::*; #(
  parameter int STEPS = CORDIC_STEPS_DEF,
  parameter int TW    = 1
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    en,
  input  logic                    v_in,
  input  logic signed [CW-1:0]    xs_in,
  input  logic signed [CW-1:0]    ys_in,
  input  logic [TW-1:0]           tag_in,
  output logic                    v_out,
  output logic signed [ANG_W-1:0] ang_out,
  output logic [TW-1:0]           tag_out
);

  logic signed [CW-1:0] xr [0:STEPS-1];
  logic signed [CW-1:0] yr [0:STEPS-1];
  logic signed [AW-1:0] ar [0:STEPS];
  logic                 zr [0:STEPS];
  logic [TW-1:0]        tg [0:STEPS];
  logic                 v  [0:STEPS];
  logic signed [AW-1:0] sum;

  // Pre-rotate the left half plane by a quarter turn
  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (en) begin
      v[0] <= v_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      zr[0] <= (xs_in == '0) && (ys_in == '0);
      tg[0] <= tag_in;
      if (xs_in < 0) begin
        if (ys_in >= 0) begin
          xr[0] <= ys_in;
          yr[0] <= -xs_in;
          ar[0] <= ANG_QUARTER;
        end else begin
          xr[0] <= -ys_in;
          yr[0] <= xs_in;
          ar[0] <= -ANG_QUARTER;
        end
      end else begin
        xr[0] <= xs_in;
        yr[0] <= ys_in;
        ar[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_it
    always_ff @(posedge clk) begin
      if (rst) begin
        v[i+1] <= 1'b0;
      end else if (en) begin
        v[i+1] <= v[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        zr[i+1] <= zr[i];
        tg[i+1] <= tg[i];
        if (yr[i] >= 0) begin
          ar[i+1] <= ar[i] + atan_val(i);
        end else begin
          ar[i+1] <= ar[i] - atan_val(i);
        end
      end
    end

    if (i < STEPS - 1) begin : g_xy
      logic signed [CW-1:0] dx;
      logic signed [CW-1:0] dy;

      assign dx = yr[i] >>> i;
      assign dy = xr[i] >>> i;

      always_ff @(posedge clk) begin
        if (en) begin
          if (yr[i] >= 0) begin
            xr[i+1] <= xr[i] + dx;
            yr[i+1] <= yr[i] - dy;
          end else begin
            xr[i+1] <= xr[i] - dx;
            yr[i+1] <= yr[i] + dy;
          end
        end
      end
    end
  end

  // Round to a binary angle; the slice wraps +pi onto -pi
  assign sum = ar[STEPS] + ANG_ROUND;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_out <= 1'b0;
    end else if (en) begin
      v_out <= v[STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ang_out <= zr[STEPS] ? '0 : sum[ANG_LSB +: ANG_W];
      tag_out <= tg[STEPS];
    end
  end

endmodule

// File: hw/rtl/lprt_bin_div.sv
module lprt_bin_div import lprt_pkg::*; #(
  parameter int LW = 7,
  parameter int TW = 1
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  v_in,
  input  logic [ANG_W+LW-1:0]   num,
  input  logic [ANG_W-1:0]      span,
  input  logic [LW-1:0]         lines,
  input  logic [TW-1:0]         tag_in,
  output logic                  v_out,
  output logic [LW-1:0]         bin_out,
  output logic [TW-1:0]         tag_out
);

  localparam int NW = ANG_W + LW;

  logic [NW-1:0] rem [0:LW-1];
  logic [LW-1:0] q   [0:LW];
  logic          ovf [0:LW];
  logic [TW-1:0] tg  [0:LW];
  logic          v   [0:LW];
  logic [LW-1:0] lim;

  // Quotient beyond LW bits always clamps, so flag it up front
  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (en) begin
      v[0] <= v_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= num;
      q[0]   <= '0;
      ovf[0] <= num >= {span, {LW{1'b0}}};
      tg[0]  <= tag_in;
    end
  end

  for (genvar j = 0; j < LW; j++) begin : g_st
    logic [NW-1:0] cmp;
    logic          take;

    assign cmp  = NW'(span) << (LW - 1 - j);
    assign take = rem[j] >= cmp;

    always_ff @(posedge clk) begin
      if (rst) begin
        v[j+1] <= 1'b0;
      end else if (en) begin
        v[j+1] <= v[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        q[j+1]   <= LW'({q[j], take});
        ovf[j+1] <= ovf[j];
        tg[j+1]  <= tg[j];
      end
    end

    if (j < LW - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          rem[j+1] <= take ? rem[j] - cmp : rem[j];
        end
      end
    end
  end

  assign lim = lines - LW'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      v_out <= 1'b0;
    end else if (en) begin
      v_out <= v[LW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      bin_out <= (ovf[LW] || (q[LW] > lim)) ? lim : q[LW];
      tag_out <= tg[LW];
    end
  end

endmodule

// File: hw/rtl/lprt_out_fifo.sv
module lprt_out_fifo import lprt_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  res_t din,
  input  logic ready,
  output logic dvalid,
  output res_t dout,
  output logic full
);

  res_t       mem [0:1];
  logic       wp;
  logic       rp;
  logic [1:0] cnt;
  logic       pop;

  assign dvalid = cnt != 2'd0;
  assign pop    = dvalid && ready;
  assign full   = cnt[1];
  assign dout   = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      cnt <= cnt + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= din;
    end
  end

endmodule

// File: hw/rtl/lidar_point_ring_and_time_tagger.sv
// Lidar point ring binning and time tagging. Each point transaction on pt gives exactly one
// result transaction on res: x, y and z pass through, intensity is saturated to an 8-bit
// reflectivity, the elevation atan2(z, hypot(x,y)) is binned into one of ring_count rings
// between elev_min and elev_max (truncated, clamped to 0..lines-1), and the azimuth
// atan2(y,x) is mapped to floor((az+32768)*frame_len/65536) ns. Angles are 16-bit
// binary angles (32768 = pi). The block takes one point per clock while the output buffer
// is not full. The pipeline is two square-and-sum stages, 32 stages of the bit-per-stage
// radius square root, CORDIC_STEPS+2 stages of the two parallel CORDIC units, one scaling
// stage, clog2(MAX_LINES+1)+2 stages of the ring divider and the output buffer. A two-entry
// output buffer keeps pt.ready high while one result waits on res; pt.ready drops only when
// both entries are full. Registers sit on an APB port at byte addresses 0, 4, 8, 12 and must
// be written only while no point is in flight.
module lidar_point_ring_and_time_tagger import lprt_pkg::*; #(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF,
  parameter int MAX_LINES    = MAX_LINES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  lprt_point_if.sink        pt,
  lprt_result_if.source     res,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  localparam int LW       = $clog2(MAX_LINES + 1);
  localparam int NW       = ANG_W + LW;
  localparam int PIPE_TW  = 3*COORD_W + REFL_W + 1;
  localparam int XYZ_W    = 3*COORD_W;
  localparam int ATTR_W   = REFL_W + 1;
  localparam int DIV_TW   = PIPE_TW + PERIOD_W;
  localparam int OFS_PW   = ANG_W + PERIOD_W;

  // ---------------------------------------------------------------- registers
  logic [SL_W-1:0]         ring_count;
  logic signed [ANG_W-1:0] elev_min;
  logic signed [ANG_W-1:0] elev_max;
  logic [PERIOD_W-1:0]     frame_len;
  logic                    cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      ring_count <= RST_SCAN_LINES;
      elev_min   <= RST_ELEV_MIN;
      elev_max   <= RST_ELEV_MAX;
      frame_len  <= RST_FRAME_PERIOD;
    end else if (cfg_wr) begin
      unique case (paddr[ADDR_W-1:2])
        REG_SCAN_LINES:   ring_count <= pwdata[SL_W-1:0];
        REG_ELEV_MIN:     elev_min   <= pwdata[ANG_W-1:0];
        REG_ELEV_MAX:     elev_max   <= pwdata[ANG_W-1:0];
        REG_FRAME_PERIOD: frame_len  <= pwdata[PERIOD_W-1:0];
        default:          ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[ADDR_W-1:2])
      REG_SCAN_LINES:   prdata = DATA_W'(ring_count);
      REG_ELEV_MIN:     prdata = DATA_W'({elev_min});
      REG_ELEV_MAX:     prdata = DATA_W'({elev_max});
      REG_FRAME_PERIOD: prdata = DATA_W'(frame_len);
      default:          prdata = '0;
    endcase
  end

  // Derived settings; the user must keep them stable while points are in flight, the block does not enforce it
  logic [LW-1:0]           lines;
  logic signed [ANG_W:0]   span_d;
  logic [ANG_W-1:0]        span;
  logic [PERIOD_W-1:0]     period;

  always_comb begin
    if (ring_count == '0) begin
      lines = LW'(1);
    end else if (int'(ring_count) > MAX_LINES) begin
      lines = LW'(MAX_LINES);
    end else begin
      lines = LW'(ring_count);
    end
  end

  // Floor the span at one unit so inverted ranges still divide
  assign span_d = (ANG_W+1)'(elev_max) - (ANG_W+1)'(elev_min);
  assign span   = (span_d < 1) ? ANG_W'(1) : span_d[ANG_W-1:0];
  assign period = (frame_len == '0) ? PERIOD_W'(1) : frame_len;

  // ---------------------------------------------------------------- flow control
  // The whole pipeline advances together; it holds only when the output buffer is full.
  logic en;
  logic fifo_full;

  assign en       = !fifo_full;
  assign pt.ready = en;

  // ---------------------------------------------------------------- stage A: squares
  logic signed [2*COORD_W-1:0] xw;
  logic signed [2*COORD_W-1:0] yw;
  logic signed [2*COORD_W-1:0] px;
  logic signed [2*COORD_W-1:0] py;
  logic [REFL_W-1:0]           refl;
  logic                        v_a;
  logic [SQ_W-1:0]             sq_x;
  logic [SQ_W-1:0]             sq_y;
  logic [PIPE_TW-1:0]          tag_a;

  assign xw = (2*COORD_W)'(pt.x);
  assign yw = (2*COORD_W)'(pt.y);
  assign px = xw * xw;
  assign py = yw * yw;

  // Saturate the raw intensity
  always_comb begin
    if (pt.intensity < 0) begin
      refl = '0;
    end else if (pt.intensity > 255) begin
      refl = '1;
    end else begin
      refl = pt.intensity[REFL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_a <= 1'b0;
    end else if (en) begin
      v_a <= pt.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_x  <= px[SQ_W-1:0];
      sq_y  <= py[SQ_W-1:0];
      tag_a <= {pt.x, pt.y, pt.z, refl, pt.last_point};
    end
  end

  // ---------------------------------------------------------------- stage B: radius squared
  logic                     v_b;
  logic [RAD_W-1:0]         rad_b;
  logic [PIPE_TW-1:0]       tag_b;
  logic [RAD_W-RAD_SHIFT-1:0] r2;

  assign r2 = (RAD_W-RAD_SHIFT)'(sq_x) + (RAD_W-RAD_SHIFT)'(sq_y);

  always_ff @(posedge clk) begin
    if (rst) begin
      v_b <= 1'b0;
    end else if (en) begin
      v_b <= v_a;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rad_b <= {r2, {RAD_SHIFT{1'b0}}};
      tag_b <= tag_a;
    end
  end

  // ---------------------------------------------------------------- radius square root
  logic                      v_s;
  logic [ROOT_W-1:0]         root_s;
  logic [PIPE_TW-1:0]        tag_s;
  logic signed [COORD_W-1:0] x_s;
  logic signed [COORD_W-1:0] y_s;
  logic signed [COORD_W-1:0] z_s;
  logic [ATTR_W-1:0]         attr_s;

  lprt_isqrt #(
    .TW(PIPE_TW)
  ) u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .v_in     (v_b),
    .rad_in   (rad_b),
    .tag_in   (tag_b),
    .v_out    (v_s),
    .root_out (root_s),
    .tag_out  (tag_s)
  );

  assign x_s    = tag_s[PIPE_TW-1 -: COORD_W];
  assign y_s    = tag_s[PIPE_TW-COORD_W-1 -: COORD_W];
  assign z_s    = tag_s[PIPE_TW-2*COORD_W-1 -: COORD_W];
  assign attr_s = tag_s[ATTR_W-1:0];

  // ---------------------------------------------------------------- elevation and azimuth
  logic signed [CW-1:0]    el_xs;
  logic signed [CW-1:0]    el_ys;
  logic signed [CW-1:0]    az_xs;
  logic signed [CW-1:0]    az_ys;
  logic                    v_e;
  logic                    v_z;
  logic signed [ANG_W-1:0] el_ang;
  logic signed [ANG_W-1:0] az_ang;
  logic [XYZ_W-1:0]        tag_e;
  logic [ATTR_W-1:0]       tag_z;

  assign el_xs = $signed(CW'(root_s));
  assign el_ys = CW'(z_s) <<< GUARD;
  assign az_xs = CW'(x_s) <<< GUARD;
  assign az_ys = CW'(y_s) <<< GUARD;

  lprt_cordic #(
    .STEPS (CORDIC_STEPS),
    .TW    (XYZ_W)
  ) u_cordic_el (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .v_in    (v_s),
    .xs_in   (el_xs),
    .ys_in   (el_ys),
    .tag_in  ({x_s, y_s, z_s}),
    .v_out   (v_e),
    .ang_out (el_ang),
    .tag_out (tag_e)
  );

  lprt_cordic #(
    .STEPS (CORDIC_STEPS),
    .TW    (ATTR_W)
  ) u_cordic_az (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .v_in    (v_s),
    .xs_in   (az_xs),
    .ys_in   (az_ys),
    .tag_in  (attr_s),
    .v_out   (v_z),
    .ang_out (az_ang),
    .tag_out (tag_z)
  );

  // ---------------------------------------------------------------- stage C: scaling
  // Negative offsets from elev_min always land in ring 0, so drop them to zero here.
  logic signed [ANG_W:0]   diff;
  logic [ANG_W-1:0]        az_u;
  logic [OFS_PW-1:0]       ofs_prod;
  logic                    v_c;
  logic [NW-1:0]           num_c;
  logic [DIV_TW-1:0]       tag_c;

  assign diff     = (ANG_W+1)'(el_ang) - (ANG_W+1)'(elev_min);
  assign az_u     = {~az_ang[ANG_W-1], az_ang[ANG_W-2:0]};
  assign ofs_prod = OFS_PW'(az_u) * OFS_PW'(period);

  always_ff @(posedge clk) begin
    if (rst) begin
      v_c <= 1'b0;
    end else if (en) begin
      v_c <= v_e && v_z;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num_c <= (diff > 0) ? NW'(diff[ANG_W-1:0]) * NW'(lines) : '0;
      tag_c <= {tag_e, tag_z, ofs_prod[OFS_PW-1 -: PERIOD_W]};
    end
  end

  // ---------------------------------------------------------------- ring divider
  logic              v_d;
  logic [LW-1:0]     bin_d;
  logic [DIV_TW-1:0] tag_d;
  res_t              res_d;
  res_t              res_q;

  lprt_bin_div #(
    .LW (LW),
    .TW (DIV_TW)
  ) u_bin_div (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .v_in    (v_c),
    .num     (num_c),
    .span    (span),
    .lines   (lines),
    .tag_in  (tag_c),
    .v_out   (v_d),
    .bin_out (bin_d),
    .tag_out (tag_d)
  );

  always_comb begin
    res_d.x_out        = tag_d[DIV_TW-1 -: COORD_W];
    res_d.y_out        = tag_d[DIV_TW-COORD_W-1 -: COORD_W];
    res_d.z_out        = tag_d[DIV_TW-2*COORD_W-1 -: COORD_W];
    res_d.reflectivity = tag_d[PERIOD_W+1 +: REFL_W];
    res_d.last_out     = tag_d[PERIOD_W];
    res_d.time_ofs     = tag_d[PERIOD_W-1:0];
    res_d.ring_line    = RING_W'(bin_d);
  end

  // ---------------------------------------------------------------- output buffer
  lprt_out_fifo u_out_fifo (
    .clk    (clk),
    .rst    (rst),
    .push   (v_d && en),
    .din    (res_d),
    .ready  (res.ready),
    .dvalid (res.valid),
    .dout   (res_q),
    .full   (fifo_full)
  );

  assign res.x_out        = res_q.x_out;
  assign res.y_out        = res_q.y_out;
  assign res.z_out        = res_q.z_out;
  assign res.reflectivity = res_q.reflectivity;
  assign res.ring_line    = res_q.ring_line;
  assign res.time_ofs     = res_q.time_ofs;
  assign res.last_out     = res_q.last_out;

endmodule

// File: hw/rtl/lprt_checker.sv
`include "lidar_point_ring_and_time_tagger_macros.svh"

module lprt_checker import lprt_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic              psel,
  input logic              penable,
  input logic              pwrite,
  input logic [ADDR_W-1:0] paddr,
  input logic [DATA_W-1:0] pwdata,
  input logic [DATA_W-1:0] prdata,
  input logic              pready
);

  logic                period_sel;
  logic                period_wr;
  logic [PERIOD_W-1:0] rd_period;
  logic [PERIOD_W-1:0] wr_period;

  assign period_sel = paddr[ADDR_W-1:2] == REG_FRAME_PERIOD;
  assign period_wr  = psel && penable && pwrite && period_sel;
  assign rd_period  = prdata[PERIOD_W-1:0];
  assign wr_period  = pwdata[PERIOD_W-1:0];

  // A stalled result stays offered
  `LPRT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
  // Input backpressure only comes from a full output buffer
  `LPRT_ASSERT_NOW(a_stall_full, !in_ready, out_valid)
  // A frame period write reads back on the next cycle
  `LPRT_ASSERT_NEXT(a_period_rb, period_wr, !period_sel || (rd_period == $past(wr_period)))
  // The register port never inserts wait states
  `LPRT_ASSERT_NOW(a_pready, psel, pready)

endmodule

bind lidar_point_ring_and_time_tagger lprt_checker u_lprt_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (pt.ready),
  .out_valid (res.valid),
  .out_ready (res.ready),
  .psel      (psel),
  .penable   (penable),
  .pwrite    (pwrite),
  .paddr     (paddr),
  .pwdata    (pwdata),
  .prdata    (prdata),
  .pready    (pready)
);
